// ===== rtl/scaled_totalizer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled totalizer unit
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_TOTALIZER_UNIT_ASSERT_SVH
`define SCALED_TOTALIZER_UNIT_ASSERT_SVH

// Same-cycle implication
`define STU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stu assertion failed");

// Next-cycle implication
`define STU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stu assertion failed");

`endif

// ===== rtl/stu_pkg.sv =====
// ----------------------------------------------------------------------------
// stu_pkg
// Types, codes and helper functions shared by the scaled totalizer unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 5;
    localparam int CODE_W     = 5;
    localparam int DIV_W      = 14;  // largest divisor is 120 * 100
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Unit divisors and tick period of hours mode
    localparam int HOUR_TICKS = 30;
    localparam int HOUR_DIV   = 120;
    localparam int MIN_DIV    = 60;
    localparam int DEC_ONE    = 10;
    localparam int DEC_TWO    = 100;

    // Unit mode codes
    localparam logic [1:0] UNIT_HOURS   = 2'd0;
    localparam logic [1:0] UNIT_MINUTES = 2'd1;
    localparam logic [1:0] UNIT_SECONDS = 2'd2;

    // Resolution codes
    localparam logic [1:0] RES_ONE = 2'd1;
    localparam logic [1:0] RES_TWO = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_CODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_CODE   = 3'd5;

    typedef enum logic [1:0] {
        FAC_1,
        FAC_10,
        FAC_100
    } factor_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_a;
        logic signed [SAMPLE_W-1:0] sample_b;
        logic                       clear_first;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] shown_a;
        logic signed [SUM_W-1:0] shown_b;
        logic                    totals_updated;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        unit_mode;
        logic [1:0]        resolution;
        logic [CODE_W-1:0] sensor_type_a;
        logic [CODE_W-1:0] sensor_type_b;
        logic [CODE_W-1:0] one_decimal_code;
        logic [CODE_W-1:0] two_decimal_code;
    } cfg_t;

    // Decimal factor of one channel
    function automatic factor_t stu_factor(
        input logic [1:0]        res,
        input logic [CODE_W-1:0] sensor,
        input logic [CODE_W-1:0] one_code,
        input logic [CODE_W-1:0] two_code
    );
        factor_t f;
        if (res == RES_ONE && sensor >= one_code)
            f = FAC_10;
        else if (res == RES_TWO && sensor >= two_code)
            f = FAC_100;
        else if (res == RES_TWO && sensor == one_code)
            f = FAC_10;
        else
            f = FAC_1;
        return f;
    endfunction

    // Combined divisor: unit divisor times decimal factor
    function automatic logic [DIV_W-1:0] stu_divisor(
        input logic [1:0] mode,
        input factor_t    fac
    );
        int base;
        int prod;
        case (mode)
            UNIT_HOURS:   base = HOUR_DIV;
            UNIT_MINUTES: base = MIN_DIV;
            default:      base = 1;
        endcase
        case (fac)
            FAC_10:  prod = base * DEC_ONE;
            FAC_100: prod = base * DEC_TWO;
            default: prod = base;
        endcase
        return DIV_W'(prod);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stu_if.sv =====
// ----------------------------------------------------------------------------
// stu_if
// Valid/ready channels of the scaled totalizer: tick items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stu_in_if;
    import stu_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stu_out_if;
    import stu_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stu_cfg_if;
    import stu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/stu_cfg.sv =====
// ----------------------------------------------------------------------------
// stu_cfg
// Configuration register file. Writes are always taken; data is masked to
// the register width and writes past the last register are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stu_cfg (
    input  wire         clk,
    input  wire         rst_n,
    stu_cfg_if.sink     cfg_ch,
    output stu_pkg::cfg_t cfg
);
    import stu_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_UNIT_MODE:  cfg_reg.unit_mode        <= cfg_ch.wdata[1:0];
                REG_RESOLUTION: cfg_reg.resolution       <= cfg_ch.wdata[1:0];
                REG_SENSOR_A:   cfg_reg.sensor_type_a    <= cfg_ch.wdata[CODE_W-1:0];
                REG_SENSOR_B:   cfg_reg.sensor_type_b    <= cfg_ch.wdata[CODE_W-1:0];
                REG_ONE_CODE:   cfg_reg.one_decimal_code <= cfg_ch.wdata[CODE_W-1:0];
                REG_TWO_CODE:   cfg_reg.two_decimal_code <= cfg_ch.wdata[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stu_div.sv =====
// ----------------------------------------------------------------------------
// stu_div
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// The divisor is always positive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stu_div (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire signed [stu_pkg::SUM_W-1:0]     dividend,
    input  wire        [stu_pkg::DIV_W-1:0]     divisor,
    output logic                                done,
    output logic signed [stu_pkg::SUM_W-1:0]    quotient
);
    import stu_pkg::*;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    localparam int STEP_W = $clog2(SUM_W);

    dstate_t           state_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic              neg_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  res_reg;

    logic [SUM_W-1:0]  mag;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [SUM_W-1:0]  quo_step;

    // Magnitude of the dividend; the most negative value maps to 2^31
    assign mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

    // One restoring step
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign quo_step = {quo_reg[SUM_W-2:0], ge};

    assign done     = done_reg;
    assign quotient = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            dsr_reg   <= '0;
            quo_reg   <= '0;
            neg_reg   <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        dsr_reg   <= divisor;
                        quo_reg   <= mag;
                        neg_reg   <= dividend[SUM_W-1];
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    quo_reg  <= quo_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        res_reg   <= neg_reg ? (~quo_step + SUM_W'(1)) : quo_step;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scaled_totalizer_unit.sv =====
// ----------------------------------------------------------------------------
// scaled_totalizer_unit
// Two-channel flow totalizer with saturating sums and scaled shown values.
// ----------------------------------------------------------------------------
// Each tick item adds one signed sample per channel into a saturating 32-bit
// sum and divides the sum by the unit divisor times the channel's decimal
// factor, truncating toward zero. One item is worked at a time: a tick that
// adds steps through the add and divide states once per channel, using the
// shared one-bit-per-cycle divider; a tick that adds nothing (hours mode
// waiting, or unit mode 3) goes from the accept straight to the result state.
// A new item can be accepted while the last result waits in the output
// register. Configuration writes are always taken and must only be issued
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "scaled_totalizer_unit_assert.svh"

module scaled_totalizer_unit #(
    parameter int CHANNELS = 2
) (
    input  wire        clk,
    input  wire        rst_n,
    stu_in_if.sink     sample_ch,
    stu_out_if.source  result_ch,
    stu_cfg_if.sink    cfg_ch
);
    import stu_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_FIN
    } state_t;

    cfg_t cfg;

    state_t                  state_reg;
    logic [CH_W-1:0]         ch_reg;
    logic signed [SUM_W-1:0] sum_reg   [CHANNELS];
    logic signed [SUM_W-1:0] shown_reg [CHANNELS];
    logic [CNT_W-1:0]        cnt_reg;
    in_item_t                item_reg;
    logic                    upd_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    logic                    accept;
    logic [CNT_W-1:0]        cnt_eff;
    logic signed [SUM_W-1:0] cur_sum;
    logic [SAMPLE_W-1:0]     cur_smp;
    logic [CODE_W-1:0]       cur_sensor;
    logic [SUM_W:0]          wide_sum;
    logic signed [SUM_W-1:0] sat_sum;
    logic [DIV_W-1:0]        divisor;
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_q;
    logic                    out_free;
    logic signed [SUM_W-1:0] shown_b_w;

    // Configuration registers
    stu_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    // Shared divider
    stu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sat_sum),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Handshakes
    assign sample_ch.ready = (state_reg == S_IDLE);
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;
    assign out_free        = !out_valid_reg || result_ch.ready;

    // Tick count as seen after an optional clear
    assign cnt_eff = sample_ch.data.clear_first ? '0 : cnt_reg;

    // Saturating add for the current channel
    assign cur_sum    = sum_reg[ch_reg];
    assign cur_smp    = (ch_reg == '0) ? item_reg.sample_a : item_reg.sample_b;
    assign cur_sensor = (ch_reg == '0) ? cfg.sensor_type_a : cfg.sensor_type_b;
    assign wide_sum   = {cur_sum[SUM_W-1], cur_sum}
                      + {{(SUM_W + 1 - SAMPLE_W){cur_smp[SAMPLE_W-1]}}, cur_smp};

    always_comb
    begin
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1])
            sat_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_sum = wide_sum[SUM_W-1:0];
    end

    // Divisor for the current channel
    assign divisor   = stu_divisor(cfg.unit_mode,
                                   stu_factor(cfg.resolution, cur_sensor,
                                              cfg.one_decimal_code,
                                              cfg.two_decimal_code));
    assign div_start = (state_reg == S_ADD);

    // Second shown value, zero when only one channel is built
    generate
        if (CHANNELS > 1)
        begin : g_two
            assign shown_b_w = shown_reg[1];
        end
        else
        begin : g_one
            assign shown_b_w = '0;
        end
    endgenerate

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            upd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            out_data_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]   <= '0;
                shown_reg[i] <= '0;
            end
        end
        else
        begin
            // Drop a taken result unless the next one loads this cycle
            if (out_valid_reg && result_ch.ready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= sample_ch.data;
                        ch_reg   <= '0;
                        if (sample_ch.data.clear_first)
                        begin
                            for (int i = 0; i < CHANNELS; i++)
                            begin
                                sum_reg[i]   <= '0;
                                shown_reg[i] <= '0;
                            end
                        end
                        case (cfg.unit_mode)
                            UNIT_HOURS:
                            begin
                                if (cnt_eff < CNT_W'(HOUR_TICKS))
                                begin
                                    cnt_reg   <= cnt_eff + 1'b1;
                                    upd_reg   <= 1'b0;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    cnt_reg   <= CNT_W'(1);
                                    upd_reg   <= 1'b1;
                                    state_reg <= S_ADD;
                                end
                            end
                            UNIT_MINUTES, UNIT_SECONDS:
                            begin
                                cnt_reg   <= cnt_eff;
                                upd_reg   <= 1'b1;
                                state_reg <= S_ADD;
                            end
                            default:
                            begin
                                cnt_reg   <= cnt_eff;
                                upd_reg   <= 1'b0;
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_ADD:
                begin
                    sum_reg[ch_reg] <= sat_sum;
                    state_reg       <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        shown_reg[ch_reg] <= div_q;
                        if (ch_reg == CH_W'(CHANNELS - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_data_reg.shown_a        <= shown_reg[0];
                        out_data_reg.shown_b        <= shown_b_w;
                        out_data_reg.totals_updated <= upd_reg;
                        state_reg                   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `STU_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done, state_reg == S_DIV)
    `STU_ASSERT_NOW(a_tick_count_range, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(HOUR_TICKS))
    `STU_ASSERT_NEXT(a_result_load, clk, rst_n, (state_reg == S_FIN) && out_free, out_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire
